### hdl/cau_pkg.sv
// Shared types, constants and step functions of the complex arithmetic unit.
package cau_pkg;

    localparam int W  = 32;          // word width of every operand and result part
    localparam int F  = 16;          // fraction bits
    localparam int PW = 2 * W;       // width of one exact product
    localparam int QB = W + 1;       // quotient / root bits produced by the step chain
    localparam int SW = 2 * QB;      // width of the step source shifter

    localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_EQ  = 3'd4,
        ACT_MAG = 3'd5
    } action_t;

    typedef struct packed {
        logic [2:0]          action;
        logic signed [W-1:0] a_re;
        logic signed [W-1:0] a_im;
        logic signed [W-1:0] b_re;
        logic signed [W-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [W-1:0] res_re;
        logic signed [W-1:0] res_im;
        logic                equal_flag;
        logic                div_zero_flag;
        logic                overflow_flag;
    } rsp_t;

    // Results settled before the step chain, carried alongside it.
    typedef struct packed {
        logic [2:0]   action;
        logic [W-1:0] fix_re;
        logic [W-1:0] fix_im;
        logic         fix_ovf;
        logic         eq;
        logic         dz;
        logic         neg_re;
        logic         neg_im;
        logic         big_re;
        logic         big_im;
    } side_t;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [SW-1:0] src;
        logic [QB-1:0] q;
    } lane_t;

    typedef struct packed {
        side_t         side;
        logic [PW-1:0] den;
        logic          sq;
        lane_t         re;
        lane_t         im;
    } stage_t;

    typedef struct packed {
        logic [W-1:0] val;
        logic         ovf;
    } sat_t;

    // Clamp a signed value to the word range.
    function automatic sat_t sat_fn(logic signed [PW:0] v);
        sat_t r;
        logic fits;
        fits  = (&v[PW:W-1]) | ~(|v[PW:W-1]);
        r.ovf = ~fits;
        r.val = fits ? v[W-1:0] : (v[PW] ? MIN_VAL : MAX_VAL);
        return r;
    endfunction

    // One restoring step: a quotient bit against den, or a root bit (two source bits).
    function automatic lane_t lane_step(lane_t l, logic [PW-1:0] den, logic sq);
        lane_t       r;
        logic [SW-1:0] cand;
        logic [SW-1:0] sub;
        logic [SW-1:0] diff;
        logic          ge;
        if (sq)
        begin
            cand  = {l.rem, l.src[SW-1:SW-2]};
            sub   = {{(SW-QB-2){1'b0}}, l.q, 2'b01};
            r.src = {l.src[SW-3:0], 2'b00};
        end
        else
        begin
            cand  = {1'b0, l.rem, l.src[SW-1]};
            sub   = {2'b00, den};
            r.src = {l.src[SW-2:0], 1'b0};
        end
        ge    = (cand >= sub);
        diff  = cand - sub;
        r.rem = ge ? diff[PW-1:0] : cand[PW-1:0];
        r.q   = {l.q[QB-2:0], ge};
        return r;
    endfunction

endpackage

### hdl/cau_front.sv
// Front pipeline: input register, products, sums and step-chain setup.
module cau_front
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   req_valid,
    input  req_t   req,
    output logic   out_valid,
    output stage_t out_data
);

    typedef struct packed {
        logic [2:0]           action;
        logic signed [W-1:0]  a_re;
        logic signed [W-1:0]  a_im;
        logic signed [W-1:0]  b_re;
        logic signed [W-1:0]  b_im;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] p_x;
        logic signed [PW-1:0] p_y;
    } prod_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [W-1:0]       fix_re;
        logic [W-1:0]       fix_im;
        logic               fix_ovf;
        logic               eq;
        logic               dz;
        logic signed [PW:0] nr;
        logic signed [PW:0] ni;
        logic [PW-1:0]      den;
    } sum_t;

    logic   v0_reg, v1_reg, v2_reg, v3_reg;
    req_t   d0_reg;
    prod_t  d1_reg, d1_next;
    sum_t   d2_reg, d2_next;
    stage_t d3_reg, d3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= req_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg <= req;
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            d3_reg <= d3_next;
        end
    end

    // Products; magnitude squares a, divide squares b.
    always_comb
    begin
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        x = (d0_reg.action == ACT_MAG) ? d0_reg.a_re : d0_reg.b_re;
        y = (d0_reg.action == ACT_MAG) ? d0_reg.a_im : d0_reg.b_im;
        d1_next.action = d0_reg.action;
        d1_next.a_re   = d0_reg.a_re;
        d1_next.a_im   = d0_reg.a_im;
        d1_next.b_re   = d0_reg.b_re;
        d1_next.b_im   = d0_reg.b_im;
        d1_next.p_rr   = d0_reg.a_re * d0_reg.b_re;
        d1_next.p_ii   = d0_reg.a_im * d0_reg.b_im;
        d1_next.p_ri   = d0_reg.a_re * d0_reg.b_im;
        d1_next.p_ir   = d0_reg.a_im * d0_reg.b_re;
        d1_next.p_x    = x * x;
        d1_next.p_y    = y * y;
    end

    // Sums, saturation of the short actions, divide numerators and denominator.
    always_comb
    begin
        logic signed [W:0]  s_re;
        logic signed [W:0]  s_im;
        logic signed [PW:0] m_re;
        logic signed [PW:0] m_im;
        sat_t               r_re;
        sat_t               r_im;
        s_re = '0;
        s_im = '0;
        m_re = $signed({d1_reg.p_rr[PW-1], d1_reg.p_rr}
                       - {d1_reg.p_ii[PW-1], d1_reg.p_ii}) >>> F;
        m_im = $signed({d1_reg.p_ri[PW-1], d1_reg.p_ri}
                       + {d1_reg.p_ir[PW-1], d1_reg.p_ir}) >>> F;
        r_re = '0;
        r_im = '0;
        unique case (d1_reg.action)
            ACT_ADD:
            begin
                s_re = {d1_reg.a_re[W-1], d1_reg.a_re} + {d1_reg.b_re[W-1], d1_reg.b_re};
                s_im = {d1_reg.a_im[W-1], d1_reg.a_im} + {d1_reg.b_im[W-1], d1_reg.b_im};
                r_re = sat_fn({{(PW-W){s_re[W]}}, s_re});
                r_im = sat_fn({{(PW-W){s_im[W]}}, s_im});
            end
            ACT_SUB:
            begin
                s_re = {d1_reg.a_re[W-1], d1_reg.a_re} - {d1_reg.b_re[W-1], d1_reg.b_re};
                s_im = {d1_reg.a_im[W-1], d1_reg.a_im} - {d1_reg.b_im[W-1], d1_reg.b_im};
                r_re = sat_fn({{(PW-W){s_re[W]}}, s_re});
                r_im = sat_fn({{(PW-W){s_im[W]}}, s_im});
            end
            ACT_MUL:
            begin
                r_re = sat_fn(m_re);
                r_im = sat_fn(m_im);
            end
            default:
            begin
                r_re = '0;
                r_im = '0;
            end
        endcase
        d2_next.action  = d1_reg.action;
        d2_next.fix_re  = r_re.val;
        d2_next.fix_im  = r_im.val;
        d2_next.fix_ovf = r_re.ovf | r_im.ovf;
        d2_next.eq      = (d1_reg.action == ACT_EQ) && (d1_reg.a_re == d1_reg.b_re)
                          && (d1_reg.a_im == d1_reg.b_im);
        d2_next.dz      = (d1_reg.action == ACT_DIV) && (d1_reg.b_re == '0)
                          && (d1_reg.b_im == '0);
        d2_next.nr      = {d1_reg.p_rr[PW-1], d1_reg.p_rr} + {d1_reg.p_ii[PW-1], d1_reg.p_ii};
        d2_next.ni      = {d1_reg.p_ir[PW-1], d1_reg.p_ir} - {d1_reg.p_ri[PW-1], d1_reg.p_ri};
        d2_next.den     = d1_reg.p_x + d1_reg.p_y;
    end

    // Numerator magnitudes, quotient range check and lane setup.
    always_comb
    begin
        logic [PW:0]   n_re;
        logic [PW:0]   n_im;
        logic [PW-1:0] a_re;
        logic [PW-1:0] a_im;
        lane_t         div_re;
        n_re = d2_reg.nr[PW] ? -d2_reg.nr : d2_reg.nr;
        n_im = d2_reg.ni[PW] ? -d2_reg.ni : d2_reg.ni;
        a_re = n_re[PW-1:0];
        a_im = n_im[PW-1:0];

        d3_next.side.action  = d2_reg.action;
        d3_next.side.fix_re  = d2_reg.fix_re;
        d3_next.side.fix_im  = d2_reg.fix_im;
        d3_next.side.fix_ovf = d2_reg.fix_ovf;
        d3_next.side.eq      = d2_reg.eq;
        d3_next.side.dz      = d2_reg.dz;
        d3_next.side.neg_re  = d2_reg.nr[PW];
        d3_next.side.neg_im  = d2_reg.ni[PW];
        // Quotient needs more than QB bits: saturate.
        d3_next.side.big_re  = (a_re >> (QB - F)) >= d2_reg.den;
        d3_next.side.big_im  = (a_im >> (QB - F)) >= d2_reg.den;
        d3_next.den          = d2_reg.den;
        d3_next.sq           = (d2_reg.action == ACT_MAG);

        div_re.rem = a_re >> (QB - F);
        div_re.src = {a_re[QB-F-1:0], {F{1'b0}}, {QB{1'b0}}};
        div_re.q   = '0;

        d3_next.re.rem = d3_next.sq ? '0 : div_re.rem;
        d3_next.re.src = d3_next.sq ? {{(SW-PW){1'b0}}, d2_reg.den} : div_re.src;
        d3_next.re.q   = '0;

        d3_next.im.rem = a_im >> (QB - F);
        d3_next.im.src = {a_im[QB-F-1:0], {F{1'b0}}, {QB{1'b0}}};
        d3_next.im.q   = '0;
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

### hdl/cau_iter_stage.sv
// One stage of the step chain: a quotient or root bit on each lane.
module cau_iter_stage
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  stage_t in_data,
    output logic   out_valid,
    output stage_t out_data
);

    logic   valid_reg;
    stage_t data_reg, data_next;

    always_comb
    begin
        data_next      = in_data;
        data_next.re   = lane_step(in_data.re, in_data.den, in_data.sq);
        data_next.im   = lane_step(in_data.im, in_data.den, 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/cau_back.sv
// Result stage: signs, saturation, action select and output register.
module cau_back
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  stage_t in_data,
    output logic   rsp_valid,
    output rsp_t   rsp
);

    logic valid_reg;
    rsp_t rsp_reg, rsp_next;

    always_comb
    begin
        logic [PW:0] u_re;
        logic [PW:0] u_im;
        sat_t        q_re;
        sat_t        q_im;
        sat_t        root;
        u_re = {{(PW+1-QB){1'b0}}, in_data.re.q};
        u_im = {{(PW+1-QB){1'b0}}, in_data.im.q};
        q_re = sat_fn(in_data.side.neg_re ? -u_re : u_re);
        q_im = sat_fn(in_data.side.neg_im ? -u_im : u_im);
        if (in_data.side.big_re)
        begin
            q_re.ovf = 1'b1;
            q_re.val = in_data.side.neg_re ? MIN_VAL : MAX_VAL;
        end
        if (in_data.side.big_im)
        begin
            q_im.ovf = 1'b1;
            q_im.val = in_data.side.neg_im ? MIN_VAL : MAX_VAL;
        end
        root = sat_fn(u_re);

        rsp_next = '0;
        unique case (in_data.side.action)
            ACT_ADD, ACT_SUB, ACT_MUL:
            begin
                rsp_next.res_re        = in_data.side.fix_re;
                rsp_next.res_im        = in_data.side.fix_im;
                rsp_next.overflow_flag = in_data.side.fix_ovf;
            end
            ACT_DIV:
            begin
                if (in_data.side.dz)
                    rsp_next.div_zero_flag = 1'b1;
                else
                begin
                    rsp_next.res_re        = q_re.val;
                    rsp_next.res_im        = q_im.val;
                    rsp_next.overflow_flag = q_re.ovf | q_im.ovf;
                end
            end
            ACT_EQ:
                rsp_next.equal_flag = in_data.side.eq;
            ACT_MAG:
            begin
                rsp_next.res_re        = root.val;
                rsp_next.overflow_flag = root.ovf;
            end
            default:
                rsp_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hdl/complex_arith_unit.sv
// Top level of the pipelined complex arithmetic unit.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   req     | in        | req_valid / req_stall | action, a_re, a_im, b_re, b_im
//   rsp     | out       | rsp_valid / rsp_stall | res_re, res_im, three flags
//
// One item enters per cycle while req_stall is low.
// The depth comes from the 33-stage restoring chain that forms divide quotients
// and magnitude roots, one bit per stage, behind the front setup stages.
// Reset clears only the valid bits; no clearing pass is needed.
// A held result stalls the whole pipeline; req_stall follows rsp_stall then.
module complex_arith_unit
    import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic   en;
    logic   valid_chain [QB+1];
    stage_t data_chain  [QB+1];

    // Advance everything unless a finished result is being held.
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        cau_iter_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_data   (data_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_chain[QB]),
        .in_data   (data_chain[QB]),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

### hdl/cau_checker.sv
// Port-level checks of the complex arithmetic unit, bound to the top level.
module cau_checker
    import cau_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // Input only backs up behind a held result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("req_stall without a held result");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("held result changed");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.div_zero_flag) |-> (rsp.res_re == '0 && rsp.res_im == '0
            && !rsp.overflow_flag && !rsp.equal_flag))
        else $error("divide by zero result not clean");

    a_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.equal_flag) |-> (rsp.res_re == '0 && rsp.res_im == '0
            && !rsp.overflow_flag))
        else $error("equality result not clean");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
